@@ rtl/core/traffic_rate_history_monitor_assert.svh @@
// Assertion macros for the traffic rate history monitor
`ifndef TRAFFIC_RATE_HISTORY_MONITOR_ASSERT_SVH
`define TRAFFIC_RATE_HISTORY_MONITOR_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define TRHM_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("trhm assertion failed");

// Next-cycle implication, checked outside reset
`define TRHM_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("trhm assertion failed");

`endif

@@ rtl/core/trhm_pkg.sv @@
// Shared constants, types and helpers of the traffic rate history monitor
package trhm_pkg;

  localparam int COUNTER_BITS      = 48;
  localparam int RATE_BITS         = 40;
  localparam int TIME_BITS         = 48;
  localparam int SUM_BITS          = 52;
  localparam int CAP_BITS          = 13;
  localparam int START_BITS        = 12;
  localparam int SCALE_BITS        = 10;
  localparam int NUM_BITS          = COUNTER_BITS + SCALE_BITS;
  localparam int DEF_HISTORY_DEPTH = 4096;

  localparam logic [RATE_BITS-1:0] RATE_MAX    = '1;
  localparam logic [SUM_BITS-1:0]  SUM_MAX     = '1;
  localparam logic [CAP_BITS-1:0]  CAP_RESET   = CAP_BITS'(DEF_HISTORY_DEPTH);

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;
  localparam logic DIR_IN     = 1'b0;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // Multiply a byte delta by 1000 as 1024 - 16 - 8
  function automatic logic [NUM_BITS-1:0] scale_ms(input logic [COUNTER_BITS-1:0] d);
    logic [NUM_BITS-1:0] dx;
    dx = NUM_BITS'(d);
    return (dx << 10) - (dx << 4) - (dx << 3);
  endfunction

endpackage

@@ rtl/core/trhm_div.sv @@
// Restoring divider, one quotient bit per cycle
module trhm_div import trhm_pkg::*; #(
  parameter int NUM_W = NUM_BITS,
  parameter int DEN_W = TIME_BITS
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output div_stat_t        stat,
  output logic [NUM_W-1:0] quot
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [DEN_W-1:0] den_r;
  logic [DEN_W-1:0] rem_r;
  logic [NUM_W-1:0] quot_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DEN_W:0]   trial;
  logic             qbit;

  // Shift the next dividend bit in and try a subtract
  always_comb begin
    trial = {rem_r, quot_r[NUM_W-1]};
    qbit  = (trial >= {1'b0, den_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(NUM_W);
        den_r  <= den;
        rem_r  <= '0;
        quot_r <= num;
      end else if (busy_r) begin
        rem_r  <= qbit ? DEN_W'(trial - {1'b0, den_r}) : DEN_W'(trial);
        quot_r <= {quot_r[NUM_W-2:0], qbit};
        cnt_r  <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quot      = quot_r;

endmodule

@@ rtl/core/traffic_rate_history_monitor.sv @@
// Top level: sequencer, rate ring memory and result register of the rate monitor
//
//  channel  | dir | handshake            | payload
//  in_      | in  | in_valid / in_ready  | command, time, byte totals, pause, query
//  out_     | out | out_valid / out_ready| rates, peaks, totals, window sum, count
//  cfg_     | in  | cfg_valid / cfg_ready| history capacity
//
// A sample takes two passes of the shared divider plus sequencing before input is taken
// again. Zero elapsed time skips the divider, and a baseline goes straight to the result.
// A query walks the entries from start index to newest, one ring read each, and skips the
// walk on an empty history.
// Reset is synchronous; the ring is not cleared and needs no clearing pass.
// A result waits in the output register; input is taken again once it is loaded.
`include "traffic_rate_history_monitor_assert.svh"

module traffic_rate_history_monitor import trhm_pkg::*; #(
  parameter int HISTORY_DEPTH = DEF_HISTORY_DEPTH
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    in_command,
  input  logic [TIME_BITS-1:0]    in_timestamp_ms,
  input  logic [COUNTER_BITS-1:0] in_bytes_in_total,
  input  logic [COUNTER_BITS-1:0] in_bytes_out_total,
  input  logic                    in_paused,
  input  logic [START_BITS-1:0]   in_start_index,
  input  logic                    in_direction,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    out_recorded,
  output logic [RATE_BITS-1:0]    out_rate_in,
  output logic [RATE_BITS-1:0]    out_rate_out,
  output logic [RATE_BITS-1:0]    out_peak_in,
  output logic [RATE_BITS-1:0]    out_peak_out,
  output logic [COUNTER_BITS-1:0] out_transferred_in,
  output logic [COUNTER_BITS-1:0] out_transferred_out,
  output logic [SUM_BITS-1:0]     out_window_sum,
  output logic [CAP_BITS-1:0]     out_history_count,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CAP_BITS-1:0]     cfg_data
);

  localparam int AW = $clog2(HISTORY_DEPTH);
  localparam int CW = $clog2(HISTORY_DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_DIV_IN, S_WAIT_IN, S_DIV_OUT, S_WAIT_OUT, S_DROP, S_APPEND,
    S_QNEW, S_QCAP, S_QRD, S_QACC, S_FIN
  } state_t;

  state_t state_r;

  logic [CAP_BITS-1:0]     cap_r;
  logic                    base_valid_r;
  logic [COUNTER_BITS-1:0] base_in_r, base_out_r;
  logic [TIME_BITS-1:0]    prev_time_r;
  logic [COUNTER_BITS-1:0] prev_in_r, prev_out_r;
  logic [COUNTER_BITS-1:0] paused_in_r, paused_out_r;
  logic [RATE_BITS-1:0]    peak_in_r, peak_out_r;
  logic [AW-1:0]           head_r;
  logic [CW-1:0]           count_r;
  logic [CW-1:0]           k_r;

  logic                    cmd_r, paused_r, dir_r;
  logic [START_BITS-1:0]   start_r;
  logic [TIME_BITS-1:0]    ts_r;
  logic [COUNTER_BITS-1:0] bi_r, bo_r;
  logic [COUNTER_BITS-1:0] din_r, dout_r;
  logic [TIME_BITS-1:0]    dms_r;
  logic [RATE_BITS-1:0]    rin_r, rout_r;
  logic [SUM_BITS-1:0]     wsum_r;
  logic                    recorded_r;

  logic [2*RATE_BITS-1:0]  ring_mem [HISTORY_DEPTH];
  logic [2*RATE_BITS-1:0]  rd_data_r;

  // Result register
  logic                    out_valid_r;
  logic                    o_recorded_r;
  logic [RATE_BITS-1:0]    o_rin_r, o_rout_r, o_pin_r, o_pout_r;
  logic [COUNTER_BITS-1:0] o_tin_r, o_tout_r;
  logic [SUM_BITS-1:0]     o_wsum_r;
  logic [CAP_BITS-1:0]     o_count_r;

  div_stat_t               div_stat;
  logic                    div_start;
  logic [NUM_BITS-1:0]     div_num;
  logic [NUM_BITS-1:0]     div_quot;
  logic [RATE_BITS-1:0]    div_rate;

  logic [CW-1:0]           cap_c;
  logic [CW-1:0]           k_sel;
  logic [CW:0]             slot_sum;
  logic [AW-1:0]           slot_addr;
  logic [RATE_BITS-1:0]    walk_v;
  logic [SUM_BITS:0]       walk_sum;
  logic                    in_acc;

  // Clamp the capacity register into 1 .. depth
  always_comb begin
    if (cap_r == '0) begin
      cap_c = CW'(1);
    end else if (32'(cap_r) > 32'(HISTORY_DEPTH)) begin
      cap_c = CW'(HISTORY_DEPTH);
    end else begin
      cap_c = CW'(cap_r);
    end
  end

  // Ring slot of an oldest-based offset
  always_comb begin
    unique case (state_r)
      S_DROP:  k_sel = count_r - cap_c + CW'(1);
      S_QNEW:  k_sel = count_r - CW'(1);
      S_QRD:   k_sel = k_r;
      default: k_sel = count_r;
    endcase
    slot_sum = (CW+1)'(head_r) + (CW+1)'(k_sel);
    if (slot_sum >= (CW+1)'(HISTORY_DEPTH)) begin
      slot_addr = AW'(slot_sum - (CW+1)'(HISTORY_DEPTH));
    end else begin
      slot_addr = AW'(slot_sum);
    end
  end

  // Shared divider and rate saturation
  assign div_start = (state_r == S_DIV_IN) || (state_r == S_DIV_OUT);
  assign div_num   = (state_r == S_DIV_IN) ? scale_ms(din_r) : scale_ms(dout_r);
  assign div_rate  = (div_quot[NUM_BITS-1:RATE_BITS] != '0) ? RATE_MAX
                                                            : div_quot[RATE_BITS-1:0];

  trhm_div #(.NUM_W(NUM_BITS), .DEN_W(TIME_BITS)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (dms_r),
    .stat  (div_stat),
    .quot  (div_quot)
  );

  // Saturating window accumulation
  assign walk_v   = (dir_r == DIR_IN) ? rd_data_r[RATE_BITS-1:0]
                                      : rd_data_r[2*RATE_BITS-1:RATE_BITS];
  assign walk_sum = (SUM_BITS+1)'(wsum_r) + (SUM_BITS+1)'(walk_v);

  // Ring memory: write on append, read every cycle
  always_ff @(posedge clk) begin
    if (state_r == S_APPEND) begin
      ring_mem[slot_addr] <= {rout_r, rin_r};
    end
    rd_data_r <= ring_mem[slot_addr];
  end

  // Capacity register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_valid) begin
      cap_r <= cfg_data;
    end
  end

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;

  // Sequencer, monitor state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      base_valid_r <= 1'b0;
      base_in_r    <= '0;
      base_out_r   <= '0;
      prev_time_r  <= '0;
      prev_in_r    <= '0;
      prev_out_r   <= '0;
      paused_in_r  <= '0;
      paused_out_r <= '0;
      peak_in_r    <= '0;
      peak_out_r   <= '0;
      head_r       <= '0;
      count_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      // Release the result once taken, unless a new one is loaded now
      if (out_valid_r && out_ready && (state_r != S_FIN)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            cmd_r      <= in_command;
            paused_r   <= in_paused;
            dir_r      <= in_direction;
            start_r    <= in_start_index;
            ts_r       <= in_timestamp_ms;
            bi_r       <= in_bytes_in_total;
            bo_r       <= in_bytes_out_total;
            din_r      <= in_bytes_in_total - prev_in_r;
            dout_r     <= in_bytes_out_total - prev_out_r;
            dms_r      <= in_timestamp_ms - prev_time_r;
            wsum_r     <= '0;
            recorded_r <= 1'b0;
            if (in_command == CMD_QUERY) begin
              rin_r   <= '0;
              rout_r  <= '0;
              state_r <= S_QNEW;
            end else if (!base_valid_r) begin
              if (in_timestamp_ms != '0) begin
                base_valid_r <= 1'b1;
                base_in_r    <= in_bytes_in_total;
                base_out_r   <= in_bytes_out_total;
                prev_time_r  <= in_timestamp_ms;
                prev_in_r    <= in_bytes_in_total;
                prev_out_r   <= in_bytes_out_total;
              end
              rin_r   <= '0;
              rout_r  <= '0;
              state_r <= S_FIN;
            end else if (in_timestamp_ms == prev_time_r) begin
              rin_r   <= RATE_MAX;
              rout_r  <= RATE_MAX;
              state_r <= S_DROP;
            end else begin
              rin_r   <= '0;
              rout_r  <= '0;
              state_r <= S_DIV_IN;
            end
          end
        end
        S_DIV_IN:  state_r <= S_WAIT_IN;
        S_WAIT_IN: begin
          if (div_stat.done) begin
            rin_r   <= div_rate;
            state_r <= S_DIV_OUT;
          end
        end
        S_DIV_OUT: state_r <= S_WAIT_OUT;
        S_WAIT_OUT: begin
          if (div_stat.done) begin
            rout_r  <= div_rate;
            state_r <= S_DROP;
          end
        end
        S_DROP: begin
          // Drop the oldest entries until the new one fits
          if (count_r >= cap_c) begin
            head_r  <= slot_addr;
            count_r <= cap_c - CW'(1);
          end
          state_r <= S_APPEND;
        end
        S_APPEND: begin
          count_r <= count_r + CW'(1);
          if (!paused_r) begin
            if (rin_r > peak_in_r) begin
              peak_in_r <= rin_r;
            end
            if (rout_r > peak_out_r) begin
              peak_out_r <= rout_r;
            end
          end else begin
            paused_in_r  <= paused_in_r + din_r;
            paused_out_r <= paused_out_r + dout_r;
          end
          prev_time_r <= ts_r;
          prev_in_r   <= bi_r;
          prev_out_r  <= bo_r;
          recorded_r  <= 1'b1;
          state_r     <= S_FIN;
        end
        S_QNEW: begin
          state_r <= (count_r == '0) ? S_FIN : S_QCAP;
        end
        S_QCAP: begin
          rin_r  <= rd_data_r[RATE_BITS-1:0];
          rout_r <= rd_data_r[2*RATE_BITS-1:RATE_BITS];
          k_r    <= CW'(start_r);
          if (32'(start_r) >= 32'(count_r)) begin
            state_r <= S_FIN;
          end else begin
            state_r <= S_QRD;
          end
        end
        S_QRD: state_r <= S_QACC;
        S_QACC: begin
          wsum_r <= (walk_sum > (SUM_BITS+1)'(SUM_MAX)) ? SUM_MAX
                                                        : walk_sum[SUM_BITS-1:0];
          k_r    <= k_r + CW'(1);
          state_r <= ((k_r + CW'(1)) >= count_r) ? S_FIN : S_QRD;
        end
        S_FIN: begin
          // Load the result once the output register is free
          if (!out_valid_r || out_ready) begin
            out_valid_r  <= 1'b1;
            o_recorded_r <= recorded_r;
            o_rin_r      <= rin_r;
            o_rout_r     <= rout_r;
            o_pin_r      <= peak_in_r;
            o_pout_r     <= peak_out_r;
            o_wsum_r     <= wsum_r;
            o_count_r    <= CAP_BITS'(count_r);
            if (count_r == '0) begin
              o_tin_r  <= '0;
              o_tout_r <= '0;
            end else begin
              o_tin_r  <= prev_in_r - base_in_r - paused_in_r;
              o_tout_r <= prev_out_r - base_out_r - paused_out_r;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid           = out_valid_r;
  assign out_recorded        = o_recorded_r;
  assign out_rate_in         = o_rin_r;
  assign out_rate_out        = o_rout_r;
  assign out_peak_in         = o_pin_r;
  assign out_peak_out        = o_pout_r;
  assign out_transferred_in  = o_tin_r;
  assign out_transferred_out = o_tout_r;
  assign out_window_sum      = o_wsum_r;
  assign out_history_count   = o_count_r;

  // Checks
  `TRHM_ASSERT_NOW(a_count_in_depth, 1'b1, 32'(count_r) <= 32'(HISTORY_DEPTH))
  `TRHM_ASSERT_NOW(a_idle_div_quiet, state_r == S_IDLE, !div_stat.busy)
  `TRHM_ASSERT_NEXT(a_append_holds, state_r == S_APPEND, count_r != '0)
  `TRHM_ASSERT_NEXT(a_cmd_kept, (state_r == S_DROP) && !cmd_r, state_r == S_APPEND)

endmodule

@@ tb/traffic_rate_history_monitor_tb.sv @@
// Self-checking testbench of the traffic rate history monitor
`timescale 1ns / 1ps

module traffic_rate_history_monitor_tb;
  import trhm_pkg::*;

  localparam logic DIR_OUT = 1'b1;
  localparam int   DEPTH   = DEF_HISTORY_DEPTH;

  typedef struct packed {
    logic                    recorded;
    logic [RATE_BITS-1:0]    rate_in;
    logic [RATE_BITS-1:0]    rate_out;
    logic [RATE_BITS-1:0]    peak_in;
    logic [RATE_BITS-1:0]    peak_out;
    logic [COUNTER_BITS-1:0] xfer_in;
    logic [COUNTER_BITS-1:0] xfer_out;
    logic [SUM_BITS-1:0]     window_sum;
    logic [CAP_BITS-1:0]     count;
  } rate_result_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic                    in_command = CMD_SAMPLE;
  logic [TIME_BITS-1:0]    in_timestamp_ms = '0;
  logic [COUNTER_BITS-1:0] in_bytes_in_total = '0;
  logic [COUNTER_BITS-1:0] in_bytes_out_total = '0;
  logic                    in_paused = 1'b0;
  logic [START_BITS-1:0]   in_start_index = '0;
  logic                    in_direction = DIR_IN;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic                    out_recorded;
  logic [RATE_BITS-1:0]    out_rate_in;
  logic [RATE_BITS-1:0]    out_rate_out;
  logic [RATE_BITS-1:0]    out_peak_in;
  logic [RATE_BITS-1:0]    out_peak_out;
  logic [COUNTER_BITS-1:0] out_transferred_in;
  logic [COUNTER_BITS-1:0] out_transferred_out;
  logic [SUM_BITS-1:0]     out_window_sum;
  logic [CAP_BITS-1:0]     out_history_count;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CAP_BITS-1:0]     cfg_data = '0;

  traffic_rate_history_monitor u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_command(in_command),
    .in_timestamp_ms(in_timestamp_ms), .in_bytes_in_total(in_bytes_in_total),
    .in_bytes_out_total(in_bytes_out_total), .in_paused(in_paused),
    .in_start_index(in_start_index), .in_direction(in_direction),
    .out_valid(out_valid), .out_ready(out_ready), .out_recorded(out_recorded),
    .out_rate_in(out_rate_in), .out_rate_out(out_rate_out),
    .out_peak_in(out_peak_in), .out_peak_out(out_peak_out),
    .out_transferred_in(out_transferred_in), .out_transferred_out(out_transferred_out),
    .out_window_sum(out_window_sum), .out_history_count(out_history_count),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Shadow state of the monitor
  logic [CAP_BITS-1:0]     mdl_capacity;
  logic                    mdl_have_base;
  logic [COUNTER_BITS-1:0] mdl_base_in, mdl_base_out, mdl_prev_in, mdl_prev_out;
  logic [TIME_BITS-1:0]    mdl_prev_time;
  logic [COUNTER_BITS-1:0] mdl_paused_in, mdl_paused_out;
  logic [RATE_BITS-1:0]    mdl_peak_in, mdl_peak_out;
  logic [RATE_BITS-1:0]    mdl_ring_in [DEPTH];
  logic [RATE_BITS-1:0]    mdl_ring_out [DEPTH];
  int unsigned             mdl_head, mdl_count;

  rate_result_t pending_results[$];
  int           errors = 0;
  int           n_samples = 0, n_queries = 0, n_results = 0;
  bit           no_idle = 1'b0;
  bit           hold_active = 1'b0;
  event         start_hold;

  // Generator state for well-formed counter sequences
  logic [TIME_BITS-1:0]    gen_time;
  logic [COUNTER_BITS-1:0] gen_in, gen_out;

  function automatic logic [RATE_BITS-1:0] bytes_per_second(
      input logic [COUNTER_BITS-1:0] delta, input logic [TIME_BITS-1:0] ms);
    logic [63:0] quot;
    if (ms == 0) return RATE_MAX;
    quot = (64'(delta) * 64'd1000) / 64'(ms);
    if (quot > 64'(RATE_MAX)) return RATE_MAX;
    return quot[RATE_BITS-1:0];
  endfunction

  // Advance the shadow state by one transaction and return its result
  function automatic rate_result_t predict_result(
      input logic cmd, input logic [TIME_BITS-1:0] ts,
      input logic [COUNTER_BITS-1:0] bi, input logic [COUNTER_BITS-1:0] bo,
      input logic paused, input logic [START_BITS-1:0] start, input logic dir);
    rate_result_t r;
    logic [COUNTER_BITS-1:0] din, dout;
    logic [TIME_BITS-1:0] dms;
    logic [63:0] sum, v;
    int unsigned cap, k;
    r = '0;
    if (cmd == CMD_SAMPLE) begin
      if (!mdl_have_base) begin
        if (ts != 0) begin
          mdl_have_base = 1'b1;
          mdl_base_in = bi; mdl_base_out = bo;
          mdl_prev_time = ts; mdl_prev_in = bi; mdl_prev_out = bo;
        end
      end else begin
        din  = bi - mdl_prev_in;
        dout = bo - mdl_prev_out;
        dms  = ts - mdl_prev_time;
        cap  = 32'(mdl_capacity);
        if (cap < 1) cap = 1;
        if (cap > DEPTH) cap = DEPTH;
        r.rate_in  = bytes_per_second(din, dms);
        r.rate_out = bytes_per_second(dout, dms);
        while (mdl_count >= cap) begin
          mdl_head = (mdl_head + 1) % DEPTH;
          mdl_count--;
        end
        k = (mdl_head + mdl_count) % DEPTH;
        mdl_ring_in[k] = r.rate_in;
        mdl_ring_out[k] = r.rate_out;
        mdl_count++;
        if (!paused) begin
          if (r.rate_in > mdl_peak_in) mdl_peak_in = r.rate_in;
          if (r.rate_out > mdl_peak_out) mdl_peak_out = r.rate_out;
        end else begin
          mdl_paused_in  = mdl_paused_in + din;
          mdl_paused_out = mdl_paused_out + dout;
        end
        mdl_prev_time = ts; mdl_prev_in = bi; mdl_prev_out = bo;
        r.recorded = 1'b1;
      end
    end else begin
      if (mdl_count > 0) begin
        k = (mdl_head + mdl_count - 1) % DEPTH;
        r.rate_in = mdl_ring_in[k];
        r.rate_out = mdl_ring_out[k];
      end
      sum = 0;
      for (k = 32'(start); k < mdl_count; k++) begin
        v = (dir == DIR_IN) ? 64'(mdl_ring_in[(mdl_head + k) % DEPTH])
                            : 64'(mdl_ring_out[(mdl_head + k) % DEPTH]);
        sum = sum + v;
        if (sum > 64'(SUM_MAX)) sum = 64'(SUM_MAX);
      end
      r.window_sum = sum[SUM_BITS-1:0];
    end
    r.peak_in = mdl_peak_in;
    r.peak_out = mdl_peak_out;
    if (mdl_count != 0) begin
      r.xfer_in  = mdl_prev_in - mdl_base_in - mdl_paused_in;
      r.xfer_out = mdl_prev_out - mdl_base_out - mdl_paused_out;
    end
    r.count = CAP_BITS'(mdl_count);
    return r;
  endfunction

  task automatic report_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("MISMATCH %s: got 0x%0h, expected 0x%0h at %0t", field, got, want, $time);
    errors++;
  endtask

  // Send one transaction, predicting its result when it is taken
  task automatic send_item(input logic cmd, input logic [TIME_BITS-1:0] ts,
      input logic [COUNTER_BITS-1:0] bi, input logic [COUNTER_BITS-1:0] bo,
      input logic paused, input logic [START_BITS-1:0] start, input logic dir);
    int gap;
    gap = 0;
    if (!no_idle && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 5);
    @(posedge clk);
    repeat (gap) @(posedge clk);
    in_valid <= 1'b1;
    in_command <= cmd;
    in_timestamp_ms <= ts;
    in_bytes_in_total <= bi;
    in_bytes_out_total <= bo;
    in_paused <= paused;
    in_start_index <= start;
    in_direction <= dir;
    do @(posedge clk); while (!in_ready);
    in_valid <= 1'b0;
    pending_results.push_back(predict_result(cmd, ts, bi, bo, paused, start, dir));
    if (cmd == CMD_SAMPLE) n_samples++; else n_queries++;
  endtask

  task automatic send_sample(input logic [TIME_BITS-1:0] ts,
      input logic [COUNTER_BITS-1:0] bi, input logic [COUNTER_BITS-1:0] bo,
      input logic paused);
    send_item(CMD_SAMPLE, ts, bi, bo, paused, START_BITS'($urandom), 1'($urandom));
  endtask

  task automatic send_query(input logic [START_BITS-1:0] start, input logic dir);
    send_item(CMD_QUERY, 48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
              48'({$urandom, $urandom}), 1'($urandom), start, dir);
  endtask

  // Next sample of a well-formed, mostly increasing counter sequence
  task automatic send_next_sample();
    gen_time = gen_time + 48'($urandom_range(1, 2000));
    gen_in   = gen_in + (($urandom_range(0, 7) == 0)
                         ? 48'({$urandom, $urandom} % 64'h100_0000_0000)
                         : 48'($urandom_range(0, 200000)));
    gen_out  = gen_out + 48'($urandom_range(0, 200000));
    send_sample(gen_time, gen_in, gen_out, $urandom_range(0, 4) == 0);
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // Write the capacity register while the block is idle
  task automatic write_capacity(input logic [CAP_BITS-1:0] value);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    mdl_capacity = value;
  endtask

  // Check each result transaction and drive the receiver's ready
  int stall_left = 0;
  always @(posedge clk) begin
    rate_result_t want;
    if (rst_n && out_valid && out_ready) begin
      n_results++;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", 64'(out_history_count), 64'd0);
      end else begin
        want = pending_results.pop_front();
        if (out_recorded !== want.recorded)
          report_mismatch("recorded", 64'(out_recorded), 64'(want.recorded));
        if (out_rate_in !== want.rate_in)
          report_mismatch("rate_in", 64'(out_rate_in), 64'(want.rate_in));
        if (out_rate_out !== want.rate_out)
          report_mismatch("rate_out", 64'(out_rate_out), 64'(want.rate_out));
        if (out_peak_in !== want.peak_in)
          report_mismatch("peak_in", 64'(out_peak_in), 64'(want.peak_in));
        if (out_peak_out !== want.peak_out)
          report_mismatch("peak_out", 64'(out_peak_out), 64'(want.peak_out));
        if (out_transferred_in !== want.xfer_in)
          report_mismatch("transferred_in", 64'(out_transferred_in), 64'(want.xfer_in));
        if (out_transferred_out !== want.xfer_out)
          report_mismatch("transferred_out", 64'(out_transferred_out), 64'(want.xfer_out));
        if (out_window_sum !== want.window_sum)
          report_mismatch("window_sum", 64'(out_window_sum), 64'(want.window_sum));
        if (out_history_count !== want.count)
          report_mismatch("history_count", 64'(out_history_count), 64'(want.count));
      end
    end
    if (hold_active) begin
      out_ready <= 1'b0;
    end else if (no_idle) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 3) == 0) begin
      stall_left = $urandom_range(0, 4);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Long receiver hold-off, counted here
  always begin
    @(start_hold);
    hold_active = 1'b1;
    repeat (1500) @(posedge clk);
    hold_active = 1'b0;
  end

  task automatic test_directed();
    send_query('0, DIR_IN);
    send_sample('0, 48'h1234, 48'h5678, 1'b0);
    send_sample(48'd1000, 48'd100, 48'd200, 1'b1);
    send_sample(48'd2000, 48'd5100, 48'd1200, 1'b1);
    send_sample(48'd3000, 48'd9100, 48'd2200, 1'b0);
    send_sample(48'd3000, 48'd9200, 48'd2300, 1'b0);
    send_sample(48'd2500, 48'd9000, 48'd2000, 1'b0);
    send_sample(48'd2501, '1, '1, 1'b0);
    send_sample('1, '0, '0, 1'b1);
    send_sample('1, 48'd7, 48'd3, 1'b0);
    send_query('0, DIR_IN);
    send_query('0, DIR_OUT);
    send_query(12'd3, DIR_IN);
    send_query(12'd9, DIR_OUT);
    send_query('1, DIR_IN);
    gen_time = 48'd10000; gen_in = 48'd9000; gen_out = 48'd9000;
  endtask

  task automatic test_capacity_extremes();
    int i;
    write_capacity(13'd0);
    send_next_sample();
    send_query('0, DIR_IN);
    write_capacity(13'd1);
    send_next_sample();
    send_query('0, DIR_OUT);
    write_capacity('1);
    for (i = 0; i < 6; i++) send_next_sample();
    send_query('0, DIR_IN);
    write_capacity(CAP_RESET);
    for (i = 0; i < 6; i++) send_next_sample();
    send_query(12'd2, DIR_OUT);
    // Lower below the count: the next append drops several entries
    write_capacity(13'd3);
    send_query('0, DIR_IN);
    send_next_sample();
    send_query('0, DIR_IN);
  endtask

  task automatic test_random_traffic(input int items);
    int i, sel;
    for (i = 0; i < items; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 65) begin
        send_next_sample();
      end else if (sel < 88) begin
        send_query((($urandom_range(0, 5) == 0) ? START_BITS'($urandom)
                    : START_BITS'($urandom_range(0, mdl_count + 1))), 1'($urandom));
      end else if (sel < 94) begin
        // Noise: arbitrary counters and time, wrapping deltas
        gen_time = 48'({$urandom, $urandom});
        gen_in = 48'({$urandom, $urandom});
        gen_out = 48'({$urandom, $urandom});
        send_sample(gen_time, gen_in, gen_out, 1'($urandom));
      end else begin
        // Repeated timestamp: zero elapsed time
        gen_in = gen_in + 48'($urandom_range(0, 1000));
        send_sample(gen_time, gen_in, gen_out, 1'($urandom));
      end
    end
  endtask

  task automatic test_backpressure();
    int i;
    wait_drained();
    -> start_hold;
    for (i = 0; i < 8; i++) send_next_sample();
    send_query('0, DIR_OUT);
  endtask

  task automatic test_sender_pause();
    wait_drained();
    send_next_sample();
    wait_drained();
    send_query('0, DIR_IN);
  endtask

  initial begin
    int phase;
    mdl_capacity = CAP_RESET;
    mdl_have_base = 1'b0;
    mdl_base_in = '0; mdl_base_out = '0; mdl_prev_in = '0; mdl_prev_out = '0;
    mdl_prev_time = '0; mdl_paused_in = '0; mdl_paused_out = '0;
    mdl_peak_in = '0; mdl_peak_out = '0; mdl_head = 0; mdl_count = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_capacity_extremes();
    for (phase = 0; phase < 7; phase++) begin
      write_capacity((phase == 3) ? 13'd0 : (phase == 5) ? 13'd64
                     : 13'($urandom_range(1, 16)));
      test_random_traffic(95);
    end
    test_backpressure();
    test_sender_pause();
    write_capacity(13'd8);
    no_idle = 1'b1;
    test_random_traffic(40);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Covered %0d samples and %0d queries, %0d results checked, %0d mismatches.",
             n_samples, n_queries, n_results, errors);
    $display("Capacity settings included 0, 1, 4096 and 8191, with stalls on both sides.");
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20ms;
    $display("Verification failed");
    $finish;
  end

endmodule
